// ===== rtl/core/llie_pkg.sv =====
// shared types, constants and helpers for the linked list insert engine
// no dependencies; used by llie_node_mem and linked_list_insert_engine
package llie_pkg;

	localparam int CAPACITY    = 32;
	localparam int VALUE_WIDTH = 32;
	localparam int PORT_W      = 32;
	localparam int COUNT_W     = 6;
	localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W       = $clog2(CAPACITY + 1);

	localparam logic [1:0] CMD_TAIL  = 2'd0;
	localparam logic [1:0] CMD_HEAD  = 2'd1;
	localparam logic [1:0] CMD_AFTER = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_NOT_FOUND = 2'd1;
	localparam logic [1:0] STS_FULL      = 2'd2;
	localparam logic [1:0] STS_EMPTY     = 2'd3;

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [CNT_W-1:0]       cnt_t;

	// write side of the node pool
	typedef struct packed {
		logic   val_we;
		idx_t   val_addr;
		value_t val_data;
		logic   link_we;
		idx_t   link_addr;
		idx_t   link_data;
	} mem_wr_t;

	// port value into stored form
	function automatic value_t to_stored(input logic [PORT_W-1:0] x);
		logic [63:0] ext;
		ext = {{(64 - PORT_W){x[PORT_W-1]}}, x};
		return ext[VALUE_WIDTH-1:0];
	endfunction

	// stored form back to port width, sign extended
	function automatic logic [PORT_W-1:0] from_stored(input value_t v);
		logic [63:0] ext;
		ext = {{(64 - VALUE_WIDTH){v[VALUE_WIDTH-1]}}, v};
		return ext[PORT_W-1:0];
	endfunction

endpackage

// ===== rtl/core/llie_node_mem.sv =====
// node pool: value and link arrays, one write port each, one registered read
// depends on llie_pkg
module llie_node_mem (
	input  logic                clk,
	input  llie_pkg::mem_wr_t   wr,
	input  logic                rd_en,
	input  llie_pkg::idx_t      rd_addr,
	output llie_pkg::value_t    rd_value,
	output llie_pkg::idx_t      rd_link
);

	llie_pkg::value_t val_mem  [llie_pkg::CAPACITY];
	llie_pkg::idx_t   link_mem [llie_pkg::CAPACITY];

	always_ff @(posedge clk) begin
		if (wr.val_we) begin
			val_mem[wr.val_addr] <= wr.val_data;
		end
		if (wr.link_we) begin
			link_mem[wr.link_addr] <= wr.link_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_value <= val_mem[rd_addr];
			rd_link  <= link_mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/linked_list_insert_engine.sv =====
// top level of the linked list insert engine: command sequencer and walker
// depends on llie_pkg and llie_node_mem
//
// A command transaction is taken when start is high and busy is low; busy is
// high only while a command walks the list or links a new node, and falls as
// its last result is shown. Results appear on status, element, element_count
// and last for exactly one cycle, marked by result_valid, and cannot be held
// off by the receiver, so the consumer must take every result in the cycle
// it is shown. Inserts at the head, and the very first insert, register their
// result as they are taken; insert at tail goes through the link state first.
// Insert after target and read list walk the list one node per cycle through
// the single read port of the node pool: a read gives one result per node, an
// insert after a match writes the new node, then links it in the link state.
// Nodes are never freed; once the pool is full every insert answers with the
// full status, save an insert after a missed target, which answers not found.
module linked_list_insert_engine (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       command,
	input  logic signed [llie_pkg::PORT_W-1:0] value,
	input  logic signed [llie_pkg::PORT_W-1:0] target,
	output logic                             result_valid,
	output logic [1:0]                       status,
	output logic signed [llie_pkg::PORT_W-1:0] element,
	output logic [llie_pkg::COUNT_W-1:0]     element_count,
	output logic                             last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_LINK = 2'd2;

	logic [1:0]        state_q;
	logic [1:0]        cmd_q;
	llie_pkg::value_t  value_q;
	llie_pkg::value_t  target_q;
	llie_pkg::idx_t    head_q;
	llie_pkg::idx_t    tail_q;
	llie_pkg::cnt_t    total_q;
	llie_pkg::idx_t    cur_q;        // node whose data is on the read port
	llie_pkg::cnt_t    step_q;       // position of that node in the walk
	llie_pkg::idx_t    link_addr_q;  // node whose link gets the new node

	logic                      res_valid_q;
	logic [1:0]                res_status_q;
	logic [llie_pkg::PORT_W-1:0] res_element_q;
	logic [llie_pkg::COUNT_W-1:0] res_count_q;
	logic                      res_last_q;

	llie_pkg::mem_wr_t mem_wr;
	logic              rd_en;
	llie_pkg::idx_t    rd_addr;
	llie_pkg::value_t  rd_value;
	llie_pkg::idx_t    rd_link;

	llie_pkg::idx_t    new_idx;
	llie_pkg::cnt_t    total_inc;
	logic              pool_full;
	logic              list_empty;
	logic              walk_last;
	logic              walk_hit;
	logic              accept;

	llie_node_mem u_node_mem (
		.clk      (clk),
		.wr       (mem_wr),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_value (rd_value),
		.rd_link  (rd_link)
	);

	// next free node is always the node count
	assign new_idx    = total_q[llie_pkg::IDX_W-1:0];
	assign total_inc  = total_q + 1'b1;
	assign pool_full  = (total_q == llie_pkg::CNT_W'(llie_pkg::CAPACITY));
	assign list_empty = (total_q == '0);
	assign walk_last  = ((step_q + 1'b1) == total_q);
	// the one compare unit, reused for every node of a search
	assign walk_hit   = (rd_value == target_q);
	assign accept     = start && (state_q == ST_IDLE);
	assign busy       = (state_q != ST_IDLE);

	// memory control
	always_comb begin
		mem_wr  = '0;
		rd_en   = 1'b0;
		rd_addr = head_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (command)
						llie_pkg::CMD_READ, llie_pkg::CMD_AFTER: begin
							rd_en   = !list_empty;
							rd_addr = head_q;
						end
						default: begin
							// new node: value plus its own link, written together
							if (!pool_full) begin
								mem_wr.val_we    = 1'b1;
								mem_wr.val_addr  = new_idx;
								mem_wr.val_data  = llie_pkg::to_stored(value);
								mem_wr.link_we   = 1'b1;
								mem_wr.link_addr = new_idx;
								mem_wr.link_data = (command == llie_pkg::CMD_HEAD) ?
									head_q : '0;
							end
						end
					endcase
				end
			end
			ST_WALK: begin
				if (cmd_q == llie_pkg::CMD_AFTER && walk_hit) begin
					// new node inherits the link of the matched node
					if (!pool_full) begin
						mem_wr.val_we    = 1'b1;
						mem_wr.val_addr  = new_idx;
						mem_wr.val_data  = value_q;
						mem_wr.link_we   = 1'b1;
						mem_wr.link_addr = new_idx;
						mem_wr.link_data = rd_link;
					end
				end else if (!walk_last) begin
					rd_en   = 1'b1;
					rd_addr = rd_link;
				end
			end
			ST_LINK: begin
				mem_wr.link_we   = 1'b1;
				mem_wr.link_addr = link_addr_q;
				mem_wr.link_data = new_idx;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cmd_q         <= llie_pkg::CMD_TAIL;
			value_q       <= '0;
			target_q      <= '0;
			head_q        <= '0;
			tail_q        <= '0;
			total_q       <= '0;
			cur_q         <= '0;
			step_q        <= '0;
			link_addr_q   <= '0;
			res_valid_q   <= 1'b0;
			res_status_q  <= llie_pkg::STS_OK;
			res_element_q <= '0;
			res_count_q   <= '0;
			res_last_q    <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q    <= command;
						value_q  <= llie_pkg::to_stored(value);
						target_q <= llie_pkg::to_stored(target);
						cur_q    <= head_q;
						step_q   <= '0;
						case (command)
							llie_pkg::CMD_READ, llie_pkg::CMD_AFTER: begin
								if (list_empty) begin
									res_valid_q   <= 1'b1;
									res_status_q  <= (command == llie_pkg::CMD_READ) ?
										llie_pkg::STS_EMPTY : llie_pkg::STS_NOT_FOUND;
									res_element_q <= '0;
									res_count_q   <= llie_pkg::COUNT_W'(total_q);
									res_last_q    <= 1'b1;
								end else begin
									state_q <= ST_WALK;
								end
							end
							default: begin
								if (pool_full) begin
									res_valid_q   <= 1'b1;
									res_status_q  <= llie_pkg::STS_FULL;
									res_element_q <= '0;
									res_count_q   <= llie_pkg::COUNT_W'(total_q);
									res_last_q    <= 1'b1;
								end else if (list_empty || command == llie_pkg::CMD_HEAD) begin
									// head insert, or first node of the list
									head_q        <= new_idx;
									if (list_empty) begin
										tail_q <= new_idx;
									end
									total_q       <= total_inc;
									res_valid_q   <= 1'b1;
									res_status_q  <= llie_pkg::STS_OK;
									res_element_q <= '0;
									res_count_q   <= llie_pkg::COUNT_W'(total_inc);
									res_last_q    <= 1'b1;
								end else begin
									// tail insert: old tail still needs its link
									link_addr_q <= tail_q;
									state_q     <= ST_LINK;
								end
							end
						endcase
					end
				end
				ST_WALK: begin
					if (cmd_q == llie_pkg::CMD_READ) begin
						res_valid_q   <= 1'b1;
						res_status_q  <= llie_pkg::STS_OK;
						res_element_q <= llie_pkg::from_stored(rd_value);
						res_count_q   <= llie_pkg::COUNT_W'(total_q);
						res_last_q    <= walk_last;
						if (walk_last) begin
							state_q <= ST_IDLE;
						end else begin
							cur_q  <= rd_link;
							step_q <= step_q + 1'b1;
						end
					end else if (walk_hit) begin
						if (pool_full) begin
							res_valid_q   <= 1'b1;
							res_status_q  <= llie_pkg::STS_FULL;
							res_element_q <= '0;
							res_count_q   <= llie_pkg::COUNT_W'(total_q);
							res_last_q    <= 1'b1;
							state_q       <= ST_IDLE;
						end else begin
							link_addr_q <= cur_q;
							state_q     <= ST_LINK;
						end
					end else if (walk_last) begin
						res_valid_q   <= 1'b1;
						res_status_q  <= llie_pkg::STS_NOT_FOUND;
						res_element_q <= '0;
						res_count_q   <= llie_pkg::COUNT_W'(total_q);
						res_last_q    <= 1'b1;
						state_q       <= ST_IDLE;
					end else begin
						cur_q  <= rd_link;
						step_q <= step_q + 1'b1;
					end
				end
				ST_LINK: begin
					// splicing after the tail moves the tail
					if (link_addr_q == tail_q) begin
						tail_q <= new_idx;
					end
					total_q       <= total_inc;
					res_valid_q   <= 1'b1;
					res_status_q  <= llie_pkg::STS_OK;
					res_element_q <= '0;
					res_count_q   <= llie_pkg::COUNT_W'(total_inc);
					res_last_q    <= 1'b1;
					state_q       <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid  = res_valid_q;
	assign status        = res_status_q;
	assign element       = res_element_q;
	assign element_count = res_count_q;
	assign last          = res_last_q;

endmodule

// ===== tb/tb_linked_list_insert_engine.sv =====
// self-checking testbench for linked_list_insert_engine: directed and random command transactions
// a list predictor inside the bench checks every result; depends on llie_pkg and the engine rtl
`timescale 1ns / 100ps

module tb_linked_list_insert_engine;

	import llie_pkg::*;

	localparam int CLK_HALF   = 6;
	localparam int TAIL_QUIET = 60;   // last transactions are sent without idle gaps
	localparam int RANDOM_CNT = 310;
	localparam int DRAIN_CYC  = CAPACITY + 8;

	// one command transaction as sent to the engine
	typedef struct {
		logic [1:0]         op;
		logic signed [31:0] val;
		logic signed [31:0] tgt;
	} list_cmd_t;

	// one result beat as the engine should show it
	typedef struct {
		logic [1:0]         sts;
		logic signed [31:0] elem;
		logic [5:0]         cnt;
		logic               lst;
	} list_beat_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start   = 1'b0;
	logic [1:0]               command = CMD_TAIL;
	logic signed [PORT_W-1:0] value   = '0;
	logic signed [PORT_W-1:0] target  = '0;
	logic                     busy;
	logic                     result_valid;
	logic [1:0]               status;
	logic signed [PORT_W-1:0] element;
	logic [COUNT_W-1:0]       element_count;
	logic                     last;

	linked_list_insert_engine i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.value        (value),
		.target       (target),
		.result_valid (result_valid),
		.status       (status),
		.element      (element),
		.element_count(element_count),
		.last         (last)
	);

	// commands waiting to be sent, and result beats waiting to be seen
	list_cmd_t  cmd_backlog[$];
	list_beat_t awaited_beats[$];

	int cmds_total = -1;
	int cmds_taken;
	int err_count;
	int shown_mismatches;

	// ---------------------------------------------------------------
	// list predictor: own copy of the node pool, head, tail and length
	// ---------------------------------------------------------------
	logic signed [31:0] pool_vals[CAPACITY];
	int                 pool_next[CAPACITY];
	int                 list_head;
	int                 list_tail;
	int                 list_len;

	function automatic void push_beat(logic [1:0] sts, logic signed [31:0] elem, logic lst);
		list_beat_t b;
		b.sts  = sts;
		b.elem = elem;
		b.cnt  = list_len[5:0];
		b.lst  = lst;
		awaited_beats.push_back(b);
	endfunction

	// apply one accepted command to the predicted list and queue its results
	function automatic void predict_list_cmd(logic [1:0] op, logic signed [31:0] v,
			logic signed [31:0] t);
		int  cur;
		int  hit_idx;
		bit  hit;
		int  n;
		cur     = list_head;
		hit_idx = 0;
		hit     = 1'b0;
		n       = list_len;
		case (op)
			CMD_READ: begin
				if (list_len == 0) begin
					push_beat(STS_EMPTY, '0, 1'b1);
				end else begin
					for (int i = 0; i < list_len; i++) begin
						push_beat(STS_OK, pool_vals[cur], i == list_len - 1);
						cur = pool_next[cur];
					end
				end
			end
			CMD_AFTER: begin
				// first match from the head wins
				for (int i = 0; i < list_len && !hit; i++) begin
					if (pool_vals[cur] == t) begin
						hit     = 1'b1;
						hit_idx = cur;
					end else begin
						cur = pool_next[cur];
					end
				end
				// a missing target is reported ahead of a full pool
				if (!hit) begin
					push_beat(STS_NOT_FOUND, '0, 1'b1);
				end else if (list_len >= CAPACITY) begin
					push_beat(STS_FULL, '0, 1'b1);
				end else begin
					pool_vals[n] = v;
					if (hit_idx == list_tail) begin
						// match at the tail acts like a tail insert
						pool_next[list_tail] = n;
						list_tail            = n;
					end else begin
						pool_next[n]       = pool_next[hit_idx];
						pool_next[hit_idx] = n;
					end
					list_len++;
					push_beat(STS_OK, '0, 1'b1);
				end
			end
			default: begin
				if (list_len >= CAPACITY) begin
					push_beat(STS_FULL, '0, 1'b1);
				end else begin
					pool_vals[n] = v;
					pool_next[n] = 0;
					if (list_len == 0) begin
						list_head = n;
						list_tail = n;
					end else if (op == CMD_TAIL) begin
						pool_next[list_tail] = n;
						list_tail            = n;
					end else begin
						pool_next[n] = list_head;
						list_head    = n;
					end
					list_len++;
					push_beat(STS_OK, '0, 1'b1);
				end
			end
		endcase
	endfunction

	// ---------------------------------------------------------------
	// clock, reset and timeout
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
	end

	// far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// ---------------------------------------------------------------
	// stimulus: directed list shapes first, then random commands
	// ---------------------------------------------------------------
	function automatic void add_cmd(logic [1:0] op, logic signed [31:0] v,
			logic signed [31:0] t);
		list_cmd_t c;
		c.op  = op;
		c.val = v;
		c.tgt = t;
		cmd_backlog.push_back(c);
	endfunction

	initial begin
		logic signed [31:0] used_vals[$];
		logic signed [31:0] v;
		logic signed [31:0] t;
		int                 pick;
		logic [1:0]         op;

		list_len  = 0;
		list_head = 0;
		list_tail = 0;

		// empty list: read answers empty, search answers not found
		add_cmd(CMD_READ,  32'h1234_5678, 32'h0);
		add_cmd(CMD_AFTER, 32'h0000_0001, 32'h0);
		// first node through a head insert, then both ends and extremes
		add_cmd(CMD_HEAD,  32'h7FFF_FFFF, 32'hFFFF_FFFF);
		add_cmd(CMD_TAIL,  32'h8000_0000, 32'h7FFF_FFFF);
		add_cmd(CMD_HEAD,  32'h0000_0000, 32'h8000_0000);
		add_cmd(CMD_TAIL,  32'hFFFF_FFFF, 32'h0);
		add_cmd(CMD_READ,  32'h0, 32'h0);
		// insert in the middle, after the tail, and a missed search
		add_cmd(CMD_AFTER, 32'h0000_0005, 32'h7FFF_FFFF);
		add_cmd(CMD_AFTER, 32'h5555_5555, 32'hFFFF_FFFF);
		add_cmd(CMD_AFTER, 32'h1111_1111, 32'hAAAA_AAAA);
		// duplicate values: search must stop on the first one
		add_cmd(CMD_TAIL,  32'h0000_0005, 32'h0);
		add_cmd(CMD_AFTER, 32'h0000_0009, 32'h0000_0005);
		add_cmd(CMD_AFTER, 32'hAAAA_AAAA, 32'h8000_0000);
		add_cmd(CMD_READ,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
		used_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
			32'h5, 32'h5555_5555, 32'h9, 32'hAAAA_AAAA};

		// random mix: the pool fills early, later inserts see the full pool
		for (int i = 0; i < RANDOM_CNT; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 25)      op = CMD_TAIL;
			else if (pick < 45) op = CMD_HEAD;
			else if (pick < 75) op = CMD_AFTER;
			else                op = CMD_READ;
			// new values are mostly fresh, sometimes repeats to build duplicates
			if ($urandom_range(0, 3) == 0)
				v = used_vals[$urandom_range(0, used_vals.size() - 1)];
			else
				v = $urandom;
			// targets mostly hit something already sent
			if ($urandom_range(0, 3) != 0)
				t = used_vals[$urandom_range(0, used_vals.size() - 1)];
			else
				t = $urandom;
			if (op != CMD_READ)
				used_vals.push_back(v);
			add_cmd(op, v, t);
		end
		cmds_total = cmd_backlog.size();
	end

	// ---------------------------------------------------------------
	// driver: one transaction in flight, random idle bursts on the send side
	// ---------------------------------------------------------------
	int gap_left   = 0;
	bit gappy_mode = 1'b1;

	always @(posedge clk or negedge arst_n) begin
		list_cmd_t c;
		bit        taken;
		if (!arst_n) begin
			start    <= 1'b0;
			command  <= CMD_TAIL;
			value    <= '0;
			target   <= '0;
			gap_left <= 0;
		end else begin
			taken = start && !busy;
			if (taken) begin
				predict_list_cmd(command, value, target);
				cmds_taken++;
			end
			// switch between stretches with and without idling
			if ($urandom_range(0, 19) == 0)
				gappy_mode = ~gappy_mode;
			if (!start || taken) begin
				if (gap_left > 0) begin
					start    <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (cmd_backlog.size() == 0) begin
					start <= 1'b0;
				end else if (gappy_mode && cmd_backlog.size() > TAIL_QUIET &&
						$urandom_range(0, 2) == 0) begin
					// idle burst: start stays low while gap_left counts down
					start    <= 1'b0;
					gap_left <= $urandom_range(0, 2);
				end else begin
					c = cmd_backlog.pop_front();
					start   <= 1'b1;
					command <= c.op;
					value   <= c.val;
					target  <= c.tgt;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: every strobed result is matched against the oldest expectation
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		list_beat_t e;
		if (arst_n && result_valid) begin
			if (awaited_beats.size() == 0) begin
				err_count++;
				if (shown_mismatches < 10) begin
					shown_mismatches++;
					$display("unexpected result: sts=%0d elem=%0d cnt=%0d last=%0d",
						status, element, element_count, last);
				end
			end else begin
				e = awaited_beats.pop_front();
				if (status !== e.sts || element !== e.elem ||
						element_count !== e.cnt || last !== e.lst) begin
					err_count++;
					if (shown_mismatches < 10) begin
						shown_mismatches++;
						$display("mismatch: exp sts=%0d elem=%0d cnt=%0d last=%0d, got sts=%0d elem=%0d cnt=%0d last=%0d",
							e.sts, e.elem, e.cnt, e.lst,
							status, element, element_count, last);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// end of run: all commands taken, all results seen, then a short drain
	// ---------------------------------------------------------------
	initial begin
		cmds_taken       = 0;
		err_count        = 0;
		shown_mismatches = 0;
		@(posedge arst_n);
		do
			@(negedge clk);
		while (cmds_taken != cmds_total || awaited_beats.size() != 0);
		repeat (DRAIN_CYC) @(negedge clk);
		if (awaited_beats.size() != 0)
			err_count++;
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/llie_pkg.sv
rtl/core/llie_node_mem.sv
rtl/core/linked_list_insert_engine.sv
tb/tb_linked_list_insert_engine.sv
